### design/fte_pkg.sv
// Package for the fiber triangle energy and gradient block.
// Types, register indexes and the 48-bit saturate helper; no dependencies.
package fte_pkg;

    localparam int unsigned W_IN  = 32;
    localparam int unsigned W_OUT = 48;

    typedef enum logic [2:0] {
        REG_RINV_00   = 3'd0,
        REG_RINV_01   = 3'd1,
        REG_RINV_10   = 3'd2,
        REG_RINV_11   = 3'd3,
        REG_HALF_AREA = 3'd4,
        REG_FIBER_XX  = 3'd5,
        REG_FIBER_XY  = 3'd6,
        REG_FIBER_YY  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] node0_x;
        logic signed [31:0] node0_y;
        logic signed [31:0] node1_x;
        logic signed [31:0] node1_y;
        logic signed [31:0] node2_x;
        logic signed [31:0] node2_y;
        logic signed [31:0] stiffness;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] energy_out;
        logic signed [47:0] grad0_x;
        logic signed [47:0] grad0_y;
        logic signed [47:0] grad1_x;
        logic signed [47:0] grad1_y;
        logic signed [47:0] grad2_x;
        logic signed [47:0] grad2_y;
    } t_out_item;

    localparam logic signed [49:0] MAX48 = 50'sd140737488355327;
    localparam logic signed [49:0] MIN48 = -50'sd140737488355328;

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] r;
        begin
            if (v > MAX48) r = MAX48[47:0];
            else if (v < MIN48) r = MIN48[47:0];
            else r = v[47:0];
            return r;
        end
    endfunction

endpackage

### design/fte_mul.sv
// Registered fixed-point multiply: 48x48 product from four 24x24 partial products,
// round half away from zero, shift by frac, saturate to 48 bits. Two register stages.
module fte_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [47:0] i_a,
    input  logic signed [47:0] i_b,
    output logic signed [47:0] o_p
);
    logic        [47:0] ua, ub;
    logic        [47:0] r_ll, r_lh, r_hl, r_hh;
    logic               r_neg;
    logic        [95:0] rnd;
    logic        [95:0] sh;
    logic        [47:0] lim;
    logic        [47:0] mag;
    logic signed [47:0] n_p;

    assign ua = i_a[47] ? 48'(-i_a) : i_a;
    assign ub = i_b[47] ? 48'(-i_b) : i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= ua[23:0]  * ub[23:0];
            r_lh  <= ua[23:0]  * ub[47:24];
            r_hl  <= ua[47:24] * ub[23:0];
            r_hh  <= ua[47:24] * ub[47:24];
            r_neg <= i_a[47] ^ i_b[47];
        end
    end

    always_comb begin
        rnd = (96'(r_hh) << 48) + (96'(r_lh) << 24) + (96'(r_hl) << 24) + 96'(r_ll)
              + (96'd1 << (FRAC_BITS - 1));
        sh  = rnd >> FRAC_BITS;
        lim = r_neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        mag = (sh[95:48] != '0 || sh[47:0] > lim) ? lim : sh[47:0];
        n_p = r_neg ? 48'(-mag) : mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_p <= n_p;
    end
endmodule

### design/fiber_triangle_energy_gradient.sv
// Top level of the fiber triangle energy and gradient pipeline.
// Uses fte_pkg and fte_mul.
//
//  channel | signals                            | handshake
//  input   | i_start, o_busy, i_in              | start & !busy
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_*  | valid & ready
//  result  | o_done, o_out                      | strobe, one cycle
//
// One item per cycle. The energy path sets when the result comes after accept: the
// edge register, five chained multiplies and four sum or saturate registers, then a
// 7-deep delay line; the gradient path is padded to match.
// o_busy stays low: the receiver never stalls, so the pipe never holds.
// Reset clears the valid chain and loads the register defaults.
module fiber_triangle_energy_gradient #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  fte_pkg::t_in_item i_in,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output logic              o_done,
    output fte_pkg::t_out_item o_out
);
    localparam int LAT = 22;
    localparam logic signed [47:0] ONE_Q  = 48'sd1 <<< FRAC_BITS;
    localparam logic signed [47:0] HALF_Q = 48'sd1 <<< (FRAC_BITS - 1);

    logic signed [31:0] r_rinv_00, r_rinv_01, r_rinv_10, r_rinv_11;
    logic signed [31:0] r_half_area, r_fiber_xx, r_fiber_xy, r_fiber_yy;
    logic [LAT-1:0] r_vld;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rinv_00 <= 32'(ONE_Q); r_rinv_01 <= '0; r_rinv_10 <= '0;
            r_rinv_11 <= 32'(ONE_Q); r_half_area <= '0;
            r_fiber_xx <= '0; r_fiber_xy <= '0; r_fiber_yy <= '0;
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start};
            if (i_cfg_valid) begin
                unique case (fte_pkg::t_reg_idx'(i_cfg_index))
                    fte_pkg::REG_RINV_00:   r_rinv_00   <= i_cfg_data;
                    fte_pkg::REG_RINV_01:   r_rinv_01   <= i_cfg_data;
                    fte_pkg::REG_RINV_10:   r_rinv_10   <= i_cfg_data;
                    fte_pkg::REG_RINV_11:   r_rinv_11   <= i_cfg_data;
                    fte_pkg::REG_HALF_AREA: r_half_area <= i_cfg_data;
                    fte_pkg::REG_FIBER_XX:  r_fiber_xx  <= i_cfg_data;
                    fte_pkg::REG_FIBER_XY:  r_fiber_xy  <= i_cfg_data;
                    fte_pkg::REG_FIBER_YY:  r_fiber_yy  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    logic signed [47:0] ra00, ra01, ra10, ra11, rha, rfx, rfy, rfz;
    assign ra00 = 48'(r_rinv_00); assign ra01 = 48'(r_rinv_01);
    assign ra10 = 48'(r_rinv_10); assign ra11 = 48'(r_rinv_11);
    assign rha  = 48'(r_half_area);
    assign rfx  = 48'(r_fiber_xx); assign rfy = 48'(r_fiber_xy);
    assign rfz  = 48'(r_fiber_yy);

    // stage A: edges
    logic signed [47:0] r_d00, r_d01, r_d10, r_d11, r_mu;
    always_ff @(posedge i_clk) begin
        r_d00 <= 48'(i_in.node0_x) - 48'(i_in.node2_x);
        r_d01 <= 48'(i_in.node1_x) - 48'(i_in.node2_x);
        r_d10 <= 48'(i_in.node0_y) - 48'(i_in.node2_y);
        r_d11 <= 48'(i_in.node1_y) - 48'(i_in.node2_y);
        r_mu  <= 48'(i_in.stiffness);
    end

    // mu delay line
    logic signed [47:0] r_mu_d [0:9];
    always_ff @(posedge i_clk) begin
        r_mu_d[0] <= r_mu;
        for (int k = 1; k < 10; k++) r_mu_d[k] <= r_mu_d[k-1];
    end

    // stage F: multiplies, then sum
    logic signed [47:0] pf [0:7];
    fte_mul #(FRAC_BITS) u_f0 (i_clk, 1'b1, r_d00, ra00, pf[0]);
    fte_mul #(FRAC_BITS) u_f1 (i_clk, 1'b1, r_d01, ra10, pf[1]);
    fte_mul #(FRAC_BITS) u_f2 (i_clk, 1'b1, r_d00, ra01, pf[2]);
    fte_mul #(FRAC_BITS) u_f3 (i_clk, 1'b1, r_d01, ra11, pf[3]);
    fte_mul #(FRAC_BITS) u_f4 (i_clk, 1'b1, r_d10, ra00, pf[4]);
    fte_mul #(FRAC_BITS) u_f5 (i_clk, 1'b1, r_d11, ra10, pf[5]);
    fte_mul #(FRAC_BITS) u_f6 (i_clk, 1'b1, r_d10, ra01, pf[6]);
    fte_mul #(FRAC_BITS) u_f7 (i_clk, 1'b1, r_d11, ra11, pf[7]);
    logic signed [47:0] r_f00, r_f01, r_f10, r_f11;
    always_ff @(posedge i_clk) begin
        r_f00 <= fte_pkg::sat48(50'(pf[0]) + 50'(pf[1]));
        r_f01 <= fte_pkg::sat48(50'(pf[2]) + 50'(pf[3]));
        r_f10 <= fte_pkg::sat48(50'(pf[4]) + 50'(pf[5]));
        r_f11 <= fte_pkg::sat48(50'(pf[6]) + 50'(pf[7]));
    end

    // energy branch: C, C-I, E, tr products, tr
    logic signed [47:0] pc [0:5];
    fte_mul #(FRAC_BITS) u_c0 (i_clk, 1'b1, r_f00, r_f00, pc[0]);
    fte_mul #(FRAC_BITS) u_c1 (i_clk, 1'b1, r_f10, r_f10, pc[1]);
    fte_mul #(FRAC_BITS) u_c2 (i_clk, 1'b1, r_f00, r_f01, pc[2]);
    fte_mul #(FRAC_BITS) u_c3 (i_clk, 1'b1, r_f10, r_f11, pc[3]);
    fte_mul #(FRAC_BITS) u_c4 (i_clk, 1'b1, r_f01, r_f01, pc[4]);
    fte_mul #(FRAC_BITS) u_c5 (i_clk, 1'b1, r_f11, r_f11, pc[5]);
    logic signed [47:0] r_c00, r_c01, r_c11, r_ci00, r_ci01, r_ci11;
    always_ff @(posedge i_clk) begin
        r_c00  <= fte_pkg::sat48(50'(pc[0]) + 50'(pc[1]));
        r_c01  <= fte_pkg::sat48(50'(pc[2]) + 50'(pc[3]));
        r_c11  <= fte_pkg::sat48(50'(pc[4]) + 50'(pc[5]));
        r_ci00 <= fte_pkg::sat48(50'(r_c00) - 50'(ONE_Q));
        r_ci01 <= r_c01;
        r_ci11 <= fte_pkg::sat48(50'(r_c11) - 50'(ONE_Q));
    end
    logic signed [47:0] e00, e01, e11;
    fte_mul #(FRAC_BITS) u_e0 (i_clk, 1'b1, r_ci00, HALF_Q, e00);
    fte_mul #(FRAC_BITS) u_e1 (i_clk, 1'b1, r_ci01, HALF_Q, e01);
    fte_mul #(FRAC_BITS) u_e2 (i_clk, 1'b1, r_ci11, HALF_Q, e11);
    logic signed [47:0] pt0, pt1, pt2;
    fte_mul #(FRAC_BITS) u_t0 (i_clk, 1'b1, e00, rfx, pt0);
    fte_mul #(FRAC_BITS) u_t1 (i_clk, 1'b1, e01, rfy, pt1);
    fte_mul #(FRAC_BITS) u_t2 (i_clk, 1'b1, e11, rfz, pt2);
    logic signed [47:0] r_tr;
    always_ff @(posedge i_clk) begin
        r_tr <= fte_pkg::sat48(50'(pt0) + 50'(pt1) + 50'(pt1) + 50'(pt2));
    end
    // area*mu: mu taken from r_mu_d[9] so that the product lines up with tr
    logic signed [47:0] am;
    fte_mul #(FRAC_BITS) u_am (i_clk, 1'b1, rha, r_mu_d[9], am);
    logic signed [47:0] en;
    fte_mul #(FRAC_BITS) u_en (i_clk, 1'b1, am, r_tr, en);
    // energy delayed to line up with the gradient
    logic signed [47:0] r_en_d [0:6];
    always_ff @(posedge i_clk) begin
        r_en_d[0] <= en;
        for (int k = 1; k < 7; k++) r_en_d[k] <= r_en_d[k-1];
    end

    // gradient branch: G and S, M products, M
    logic signed [47:0] g00, g01, g10, g11, s00, s01, s11;
    fte_mul #(FRAC_BITS) u_g0 (i_clk, 1'b1, rha, r_f00, g00);
    fte_mul #(FRAC_BITS) u_g1 (i_clk, 1'b1, rha, r_f01, g01);
    fte_mul #(FRAC_BITS) u_g2 (i_clk, 1'b1, rha, r_f10, g10);
    fte_mul #(FRAC_BITS) u_g3 (i_clk, 1'b1, rha, r_f11, g11);
    fte_mul #(FRAC_BITS) u_s0 (i_clk, 1'b1, r_mu_d[2], rfx, s00);
    fte_mul #(FRAC_BITS) u_s1 (i_clk, 1'b1, r_mu_d[2], rfy, s01);
    fte_mul #(FRAC_BITS) u_s2 (i_clk, 1'b1, r_mu_d[2], rfz, s11);
    logic signed [47:0] pm [0:7];
    fte_mul #(FRAC_BITS) u_m0 (i_clk, 1'b1, g00, s00, pm[0]);
    fte_mul #(FRAC_BITS) u_m1 (i_clk, 1'b1, g01, s01, pm[1]);
    fte_mul #(FRAC_BITS) u_m2 (i_clk, 1'b1, g00, s01, pm[2]);
    fte_mul #(FRAC_BITS) u_m3 (i_clk, 1'b1, g01, s11, pm[3]);
    fte_mul #(FRAC_BITS) u_m4 (i_clk, 1'b1, g10, s00, pm[4]);
    fte_mul #(FRAC_BITS) u_m5 (i_clk, 1'b1, g11, s01, pm[5]);
    fte_mul #(FRAC_BITS) u_m6 (i_clk, 1'b1, g10, s01, pm[6]);
    fte_mul #(FRAC_BITS) u_m7 (i_clk, 1'b1, g11, s11, pm[7]);
    logic signed [47:0] r_m00, r_m01, r_m10, r_m11;
    always_ff @(posedge i_clk) begin
        r_m00 <= fte_pkg::sat48(50'(pm[0]) + 50'(pm[1]));
        r_m01 <= fte_pkg::sat48(50'(pm[2]) + 50'(pm[3]));
        r_m10 <= fte_pkg::sat48(50'(pm[4]) + 50'(pm[5]));
        r_m11 <= fte_pkg::sat48(50'(pm[6]) + 50'(pm[7]));
    end
    // H products, H, grad2
    logic signed [47:0] ph [0:7];
    fte_mul #(FRAC_BITS) u_h0 (i_clk, 1'b1, r_m00, ra00, ph[0]);
    fte_mul #(FRAC_BITS) u_h1 (i_clk, 1'b1, r_m01, ra01, ph[1]);
    fte_mul #(FRAC_BITS) u_h2 (i_clk, 1'b1, r_m00, ra10, ph[2]);
    fte_mul #(FRAC_BITS) u_h3 (i_clk, 1'b1, r_m01, ra11, ph[3]);
    fte_mul #(FRAC_BITS) u_h4 (i_clk, 1'b1, r_m10, ra00, ph[4]);
    fte_mul #(FRAC_BITS) u_h5 (i_clk, 1'b1, r_m11, ra01, ph[5]);
    fte_mul #(FRAC_BITS) u_h6 (i_clk, 1'b1, r_m10, ra10, ph[6]);
    fte_mul #(FRAC_BITS) u_h7 (i_clk, 1'b1, r_m11, ra11, ph[7]);
    logic signed [47:0] r_h00, r_h01, r_h10, r_h11;
    logic signed [47:0] r_h00_d, r_h01_d, r_h10_d, r_h11_d;
    logic signed [47:0] r_g2x, r_g2y;
    always_ff @(posedge i_clk) begin
        r_h00 <= fte_pkg::sat48(50'(ph[0]) + 50'(ph[1]));
        r_h01 <= fte_pkg::sat48(50'(ph[2]) + 50'(ph[3]));
        r_h10 <= fte_pkg::sat48(50'(ph[4]) + 50'(ph[5]));
        r_h11 <= fte_pkg::sat48(50'(ph[6]) + 50'(ph[7]));
        r_h00_d <= r_h00;
        r_h01_d <= r_h01;
        r_h10_d <= r_h10;
        r_h11_d <= r_h11;
        r_g2x <= fte_pkg::sat48(-(50'(r_h00) + 50'(r_h01)));
        r_g2y <= fte_pkg::sat48(-(50'(r_h10) + 50'(r_h11)));
    end
    // grad2 and the held H copies (r_h*_d) line up; delayed to match the energy
    localparam int GD = 9;
    fte_pkg::t_out_item r_gd [0:GD-1];
    always_ff @(posedge i_clk) begin
        r_gd[0] <= '{energy_out: '0, grad0_x: r_h00_d, grad0_y: r_h10_d,
                     grad1_x: r_h01_d, grad1_y: r_h11_d, grad2_x: r_g2x, grad2_y: r_g2y};
        for (int k = 1; k < GD; k++) r_gd[k] <= r_gd[k-1];
    end

    always_comb begin
        o_out = r_gd[GD-1];
        o_out.energy_out = r_en_d[6];
    end
    assign o_done = r_vld[LAT-1];

`ifndef SYNTHESIS
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##LAT o_done) else $error("result lost");
    a_nodone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_start, LAT) |-> !o_done) else $error("result invented");
    a_busy: assert property (@(posedge i_clk) !o_busy) else $error("busy raised");
`endif
endmodule

### verif/fte_checker.sv
// Checker for the fiber triangle energy and gradient block: tracks register writes,
// predicts each result from accepted items and compares it. Depends on fte_pkg.
module fte_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  fte_pkg::t_in_item  i_in,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_done,
    input  fte_pkg::t_out_item i_out,
    output int                 o_fail_count,
    output int                 o_pending
);
    localparam int FRAC = 16;
    localparam longint ONE_Q = 64'sd1 <<< FRAC;
    localparam longint HALF_Q = 64'sd1 <<< (FRAC - 1);
    localparam longint TOP48 = 64'sd140737488355327;
    localparam longint BOT48 = -64'sd140737488355328;

    longint rinv00, rinv01, rinv10, rinv11, area, phi_xx, phi_xy, phi_yy;
    fte_pkg::t_out_item expected_results[$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending = expected_results.size();

    function automatic longint clamp48(longint v);
        if (v > TOP48) return TOP48;
        if (v < BOT48) return BOT48;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        logic [127:0] prod;
        logic [63:0] ua, ub, mag, lim;
        logic neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        prod = {64'd0, ua} * {64'd0, ub};
        prod = (prod + (128'd1 << (FRAC - 1))) >> FRAC;
        lim = neg ? 64'd140737488355328 : 64'd140737488355327;
        mag = (prod > {64'd0, lim}) ? lim : prod[63:0];
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic fte_pkg::t_out_item predict_triangle(fte_pkg::t_in_item it);
        longint mu, d00, d01, d10, d11, f00, f01, f10, f11, c00, c01, c11;
        longint e00, e01, e11, tr, s00, s01, s11, g00, g01, g10, g11;
        longint m00, m01, m10, m11, h00, h01, h10, h11;
        fte_pkg::t_out_item r;
        mu = it.stiffness;
        d00 = longint'(it.node0_x) - longint'(it.node2_x);
        d01 = longint'(it.node1_x) - longint'(it.node2_x);
        d10 = longint'(it.node0_y) - longint'(it.node2_y);
        d11 = longint'(it.node1_y) - longint'(it.node2_y);
        f00 = clamp48(qmul(d00, rinv00) + qmul(d01, rinv10));
        f01 = clamp48(qmul(d00, rinv01) + qmul(d01, rinv11));
        f10 = clamp48(qmul(d10, rinv00) + qmul(d11, rinv10));
        f11 = clamp48(qmul(d10, rinv01) + qmul(d11, rinv11));
        c00 = clamp48(qmul(f00, f00) + qmul(f10, f10));
        c01 = clamp48(qmul(f00, f01) + qmul(f10, f11));
        c11 = clamp48(qmul(f01, f01) + qmul(f11, f11));
        e00 = qmul(clamp48(c00 - ONE_Q), HALF_Q);
        e01 = qmul(c01, HALF_Q);
        e11 = qmul(clamp48(c11 - ONE_Q), HALF_Q);
        tr = clamp48(qmul(e00, phi_xx) + qmul(e01, phi_xy) + qmul(e01, phi_xy)
                     + qmul(e11, phi_yy));
        s00 = qmul(mu, phi_xx);
        s01 = qmul(mu, phi_xy);
        s11 = qmul(mu, phi_yy);
        g00 = qmul(area, f00);
        g01 = qmul(area, f01);
        g10 = qmul(area, f10);
        g11 = qmul(area, f11);
        m00 = clamp48(qmul(g00, s00) + qmul(g01, s01));
        m01 = clamp48(qmul(g00, s01) + qmul(g01, s11));
        m10 = clamp48(qmul(g10, s00) + qmul(g11, s01));
        m11 = clamp48(qmul(g10, s01) + qmul(g11, s11));
        h00 = clamp48(qmul(m00, rinv00) + qmul(m01, rinv01));
        h01 = clamp48(qmul(m00, rinv10) + qmul(m01, rinv11));
        h10 = clamp48(qmul(m10, rinv00) + qmul(m11, rinv01));
        h11 = clamp48(qmul(m10, rinv10) + qmul(m11, rinv11));
        r.energy_out = 48'(qmul(qmul(area, mu), tr));
        r.grad0_x = 48'(h00);
        r.grad0_y = 48'(h10);
        r.grad1_x = 48'(h01);
        r.grad1_y = 48'(h11);
        r.grad2_x = 48'(clamp48(-(h00 + h01)));
        r.grad2_y = 48'(clamp48(-(h10 + h11)));
        return r;
    endfunction

    task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
            fails++;
        end
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        fte_pkg::t_out_item want;
        if (!i_rst_n) begin
            rinv00 = ONE_Q;
            rinv01 = 0;
            rinv10 = 0;
            rinv11 = ONE_Q;
            area = 0;
            phi_xx = 0;
            phi_xy = 0;
            phi_yy = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (fte_pkg::t_reg_idx'(i_cfg_index))
                    fte_pkg::REG_RINV_00:   rinv00 = longint'($signed(i_cfg_data));
                    fte_pkg::REG_RINV_01:   rinv01 = longint'($signed(i_cfg_data));
                    fte_pkg::REG_RINV_10:   rinv10 = longint'($signed(i_cfg_data));
                    fte_pkg::REG_RINV_11:   rinv11 = longint'($signed(i_cfg_data));
                    fte_pkg::REG_HALF_AREA: area = longint'($signed(i_cfg_data));
                    fte_pkg::REG_FIBER_XX:  phi_xx = longint'($signed(i_cfg_data));
                    fte_pkg::REG_FIBER_XY:  phi_xy = longint'($signed(i_cfg_data));
                    fte_pkg::REG_FIBER_YY:  phi_yy = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding");
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("energy_out", want.energy_out, i_out.energy_out);
                    check_field("grad0_x", want.grad0_x, i_out.grad0_x);
                    check_field("grad0_y", want.grad0_y, i_out.grad0_y);
                    check_field("grad1_x", want.grad1_x, i_out.grad1_x);
                    check_field("grad1_y", want.grad1_y, i_out.grad1_y);
                    check_field("grad2_x", want.grad2_x, i_out.grad2_x);
                    check_field("grad2_y", want.grad2_y, i_out.grad2_y);
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(predict_triangle(i_in));
        end
    end
endmodule

### verif/tb_fiber_triangle_energy_gradient.sv
// Testbench top for fiber_triangle_energy_gradient: clock, reset, register
// writes and triangle stimulus. Depends on fte_pkg, fte_checker and fiber_triangle_energy_gradient.
module tb_fiber_triangle_energy_gradient;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LATENCY = 22;

    logic i_clk, i_rst_n, i_start, o_busy, i_cfg_valid, o_cfg_ready, o_done;
    logic [2:0] i_cfg_index;
    logic [31:0] i_cfg_data;
    fte_pkg::t_in_item i_in;
    fte_pkg::t_out_item o_out;
    int fail_count, pending, cycles, idle_pct;

    fiber_triangle_energy_gradient i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_in(i_in), .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_out(o_out)
    );

    fte_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_in(i_in), .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_done(o_done), .i_out(o_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(fte_pkg::t_reg_idx idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_triangle(fte_pkg::t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic drain;
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(3) == 0) return $urandom();
        return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endfunction

    task automatic load_regs(logic [31:0] r00, logic [31:0] r01, logic [31:0] r10,
                             logic [31:0] r11, logic [31:0] ar, logic [31:0] pxx,
                             logic [31:0] pxy, logic [31:0] pyy);
        write_reg(fte_pkg::REG_RINV_00, r00);
        write_reg(fte_pkg::REG_RINV_01, r01);
        write_reg(fte_pkg::REG_RINV_10, r10);
        write_reg(fte_pkg::REG_RINV_11, r11);
        write_reg(fte_pkg::REG_HALF_AREA, ar);
        write_reg(fte_pkg::REG_FIBER_XX, pxx);
        write_reg(fte_pkg::REG_FIBER_XY, pxy);
        write_reg(fte_pkg::REG_FIBER_YY, pyy);
    endtask

    initial begin
        fte_pkg::t_in_item it;
        idle_pct = 32;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items under reset, fiber and area, and mixed registers; random items in all sets
        for (int set = 0; set < 7; set++) begin
            idle_pct = set < 2 ? 32 : (set < 4 ? 66 : 0);
            case (set)
                0: ;
                1: load_regs(32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0000_8000,
                             32'h0001_0000, 32'h0000_4000, 32'h0000_2000);
                2: load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                3: load_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
                4: load_regs(32'h0000_C000, 32'hFFFF_8000, 32'h0000_4000, 32'h0001_8000,
                             32'hFFFE_0000, 32'h0000_8000, 32'hFFFF_C000, 32'h0000_8000);
                default: load_regs(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                   rand_coord(), rand_coord(), rand_coord(), rand_coord());
            endcase
            if (set < 2 || set == 4) begin
                it = '0;
                send_triangle(it);
                it = {7{32'h7FFF_FFFF}};
                send_triangle(it);
                it = {7{32'h8000_0000}};
                send_triangle(it);
                it = {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000};
                send_triangle(it);
                it = {32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000};
                send_triangle(it);
                it = {32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
                      32'h0002_0000, 32'h0002_0000, 32'hFFFF_0000};
                send_triangle(it);
            end
            for (int n = 0; n < 55; n++) begin
                it.node0_x = rand_coord();
                it.node0_y = rand_coord();
                it.node1_x = rand_coord();
                it.node1_y = rand_coord();
                it.node2_x = rand_coord();
                it.node2_y = rand_coord();
                it.stiffness = rand_coord();
                send_triangle(it);
            end
            drain();
        end

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
